// ===== sv/assert_macros.svh =====
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SXD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define SXD_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== sv/sxd_pkg.sv =====
// Types and constants of the object text decoder.
package sxd_pkg;

	// character codes
	localparam logic [7:0] CH_T  = 8'h54;
	localparam logic [7:0] CH_NL = 8'h0A;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FMT_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FMT_HIGH = 1'b1;
	localparam int unsigned TBL_W = 64;

	// format table codes
	localparam logic [1:0] TBL_ABSENT = 2'd0;
	localparam logic [1:0] TBL_FMT1   = 2'd1;
	localparam logic [1:0] TBL_FMT2   = 2'd2;
	localparam logic [1:0] TBL_FMT34  = 2'd3;

	// result format codes
	localparam logic [1:0] FMT_1 = 2'd0;
	localparam logic [1:0] FMT_2 = 2'd1;
	localparam logic [1:0] FMT_3 = 2'd2;
	localparam logic [1:0] FMT_4 = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_HEX = 2'd1;
	localparam logic [1:0] ST_BAD_OP  = 2'd2;

	localparam logic [7:0] OPCODE_MASK = 8'hFC;

	// character queue
	localparam int unsigned FIFO_DEPTH = 2;
	localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// parser modes
	typedef enum logic [3:0] {
		MODE_SEEK,
		MODE_SKIPLINE,
		MODE_SKIPADDR,
		MODE_COUNT,
		MODE_OPCODE,
		MODE_REG,
		MODE_XBPE,
		MODE_DISP,
		MODE_HALT
	} mode_t;

	// classified character
	typedef struct packed {
		logic       is_t;
		logic       is_nl;
		logic       hex_ok;
		logic [3:0] hex;
	} char_info_t;

	// one decoded instruction or error
	typedef struct packed {
		logic [7:0]  opcode;
		logic [1:0]  fmt;
		logic        flag_n;
		logic        flag_i;
		logic        flag_x;
		logic        flag_b;
		logic        flag_p;
		logic        flag_e;
		logic [19:0] operand_value;
		logic [1:0]  status;
	} result_t;

endpackage

// ===== sv/sxd_front.sv =====
// Front stage: takes characters and classifies them for the parser.
module sxd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          ch,
	input  logic                fifo_full,
	output logic                push,
	output sxd_pkg::char_info_t push_data
);

	function automatic sxd_pkg::char_info_t classify(input logic [7:0] c);
		sxd_pkg::char_info_t r;
		r.is_t   = (c == sxd_pkg::CH_T);
		r.is_nl  = (c == sxd_pkg::CH_NL);
		r.hex_ok = 1'b1;
		r.hex    = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.hex = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r.hex = c[3:0] + 4'd9;
		end else begin
			r.hex_ok = 1'b0;
		end
		return r;
	endfunction

	logic                valid_s1;
	sxd_pkg::char_info_t info_s1;
	logic                accept;

	assign push      = valid_s1 && !fifo_full;
	assign in_ready  = !valid_s1 || !fifo_full;
	assign accept    = in_valid && in_ready;
	assign push_data = info_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= classify(ch);
		end
	end

endmodule

// ===== sv/sxd_fifo.sv =====
// Short queue of classified characters between front and parser.
`include "assert_macros.svh"

module sxd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sxd_pkg::char_info_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output sxd_pkg::char_info_t pop_data
);

	sxd_pkg::char_info_t mem_q [sxd_pkg::FIFO_DEPTH];
	logic [sxd_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [sxd_pkg::FIFO_CNT_W-1:0] count_q;

	assign full      = (count_q == sxd_pkg::FIFO_CNT_W'(sxd_pkg::FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	function automatic logic [sxd_pkg::FIFO_PTR_W-1:0] next_ptr(
		input logic [sxd_pkg::FIFO_PTR_W-1:0] p
	);
		if (p == sxd_pkg::FIFO_PTR_W'(sxd_pkg::FIFO_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`SXD_NEVER(a_no_overflow, push && full, "queue push while full")
	`SXD_NEVER(a_no_underflow, pop && !not_empty, "queue pop while empty")

endmodule

// ===== sv/sxd_back.sv =====
// Parser: walks the record grammar and decodes instructions into results.
`include "assert_macros.svh"

module sxd_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fifo_not_empty,
	input  sxd_pkg::char_info_t            fifo_data,
	output logic                           pop,
	input  logic [sxd_pkg::TBL_W-1:0]      fmt_low,
	input  logic [sxd_pkg::TBL_W-1:0]      fmt_high,
	output logic                           out_valid,
	input  logic                           out_ready,
	output sxd_pkg::result_t               result
);

	sxd_pkg::mode_t   mode_q, mode_d;
	logic [2:0]       cc_q, cc_d;
	logic [7:0]       bl_q, bl_d;
	logic [7:0]       raw_q, raw_d;
	logic [3:0]       addr_q, addr_d;
	logic [19:0]      acc_q, acc_d;
	logic             out_valid_q;
	sxd_pkg::result_t out_q;

	logic             emit;
	sxd_pkg::result_t res_d;

	logic [2:0]       cc_inc;
	logic [3:0]       d;
	logic             ok;
	logic [7:0]       raw_n;
	logic [7:0]       op_n;
	logic [sxd_pkg::TBL_W-1:0] tbl;
	logic [1:0]       code;
	logic [19:0]      acc_disp;
	logic [7:0]       acc_reg;
	logic [2:0]       need;

	function automatic logic [7:0] consume(input logic [7:0] b, input logic [2:0] n);
		return (b > {5'd0, n}) ? (b - {5'd0, n}) : 8'd0;
	endfunction

	function automatic sxd_pkg::result_t fail_res(input logic [7:0] op, input logic [1:0] st);
		sxd_pkg::result_t r;
		r        = '0;
		r.opcode = op;
		r.status = st;
		return r;
	endfunction

	assign pop       = fifo_not_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result    = out_q;

	assign d        = fifo_data.hex;
	assign ok       = fifo_data.hex_ok;
	assign cc_inc   = cc_q + 3'd1;
	assign raw_n    = {raw_q[3:0], d};
	assign op_n     = raw_n & sxd_pkg::OPCODE_MASK;
	assign tbl      = op_n[7] ? fmt_high : fmt_low;
	assign code     = tbl[{op_n[6:2], 1'b0} +: 2];
	assign acc_disp = {acc_q[15:0], d};
	assign acc_reg  = {acc_q[3:0], d};
	assign need     = addr_q[0] ? 3'd5 : 3'd3;

	always_comb begin
		mode_d = mode_q;
		cc_d   = cc_q;
		bl_d   = bl_q;
		raw_d  = raw_q;
		addr_d = addr_q;
		acc_d  = acc_q;
		emit   = 1'b0;
		res_d  = '0;
		if (pop) begin
			unique case (mode_q)
				sxd_pkg::MODE_SEEK: begin
					if (fifo_data.is_t) begin
						mode_d = sxd_pkg::MODE_SKIPADDR;
						cc_d   = 3'd0;
					end else if (!fifo_data.is_nl) begin
						mode_d = sxd_pkg::MODE_SKIPLINE;
					end
				end
				sxd_pkg::MODE_SKIPLINE: begin
					if (fifo_data.is_nl) begin
						mode_d = sxd_pkg::MODE_SEEK;
					end
				end
				sxd_pkg::MODE_SKIPADDR: begin
					if (cc_inc >= 3'd6) begin
						mode_d = sxd_pkg::MODE_COUNT;
						cc_d   = 3'd0;
						bl_d   = 8'd0;
					end else begin
						cc_d = cc_inc;
					end
				end
				sxd_pkg::MODE_COUNT: begin
					if (!ok) begin
						mode_d = sxd_pkg::MODE_HALT;
						emit   = 1'b1;
						res_d  = fail_res(8'd0, sxd_pkg::ST_BAD_HEX);
					end else begin
						bl_d = {bl_q[3:0], d};
						if (cc_inc >= 3'd2) begin
							mode_d = sxd_pkg::MODE_OPCODE;
							cc_d   = 3'd0;
						end else begin
							cc_d = cc_inc;
						end
					end
				end
				sxd_pkg::MODE_OPCODE: begin
					if (cc_q == 3'd0) begin
						if (bl_q == 8'd0) begin
							// count exhausted: drop the line end
							mode_d = sxd_pkg::MODE_SEEK;
						end else if (!ok) begin
							mode_d = sxd_pkg::MODE_HALT;
							emit   = 1'b1;
							res_d  = fail_res(8'd0, sxd_pkg::ST_BAD_HEX);
						end else begin
							raw_d = {4'd0, d};
							cc_d  = 3'd1;
						end
					end else if (!ok) begin
						mode_d = sxd_pkg::MODE_HALT;
						emit   = 1'b1;
						res_d  = fail_res(8'd0, sxd_pkg::ST_BAD_HEX);
					end else begin
						raw_d = raw_n;
						cc_d  = 3'd0;
						case (code)
							sxd_pkg::TBL_ABSENT: begin
								mode_d = sxd_pkg::MODE_HALT;
								emit   = 1'b1;
								res_d  = fail_res(op_n, sxd_pkg::ST_BAD_OP);
							end
							sxd_pkg::TBL_FMT1: begin
								bl_d         = consume(bl_q, 3'd1);
								emit         = 1'b1;
								res_d.opcode = op_n;
								res_d.fmt    = sxd_pkg::FMT_1;
								res_d.status = sxd_pkg::ST_OK;
							end
							sxd_pkg::TBL_FMT2: begin
								acc_d  = 20'd0;
								mode_d = sxd_pkg::MODE_REG;
							end
							default: begin
								acc_d  = 20'd0;
								mode_d = sxd_pkg::MODE_XBPE;
							end
						endcase
					end
				end
				sxd_pkg::MODE_REG: begin
					if (!ok) begin
						mode_d = sxd_pkg::MODE_HALT;
						emit   = 1'b1;
						res_d  = fail_res(8'd0, sxd_pkg::ST_BAD_HEX);
					end else begin
						acc_d = {12'd0, acc_reg};
						if (cc_inc < 3'd2) begin
							cc_d = cc_inc;
						end else begin
							cc_d                = 3'd0;
							mode_d              = sxd_pkg::MODE_OPCODE;
							bl_d                = consume(bl_q, 3'd2);
							emit                = 1'b1;
							res_d.opcode        = raw_q & sxd_pkg::OPCODE_MASK;
							res_d.fmt           = sxd_pkg::FMT_2;
							res_d.operand_value = {12'd0, acc_reg};
							res_d.status        = sxd_pkg::ST_OK;
						end
					end
				end
				sxd_pkg::MODE_XBPE: begin
					if (!ok) begin
						mode_d = sxd_pkg::MODE_HALT;
						emit   = 1'b1;
						res_d  = fail_res(8'd0, sxd_pkg::ST_BAD_HEX);
					end else begin
						addr_d = d;
						acc_d  = 20'd0;
						cc_d   = 3'd0;
						mode_d = sxd_pkg::MODE_DISP;
					end
				end
				sxd_pkg::MODE_DISP: begin
					if (!ok) begin
						mode_d = sxd_pkg::MODE_HALT;
						emit   = 1'b1;
						res_d  = fail_res(8'd0, sxd_pkg::ST_BAD_HEX);
					end else begin
						acc_d = acc_disp;
						if (cc_inc < need) begin
							cc_d = cc_inc;
						end else begin
							cc_d                = 3'd0;
							mode_d              = sxd_pkg::MODE_OPCODE;
							bl_d                = consume(bl_q, addr_q[0] ? 3'd4 : 3'd3);
							emit                = 1'b1;
							res_d.opcode        = raw_q & sxd_pkg::OPCODE_MASK;
							res_d.fmt           = addr_q[0] ? sxd_pkg::FMT_4 : sxd_pkg::FMT_3;
							res_d.flag_n        = raw_q[1];
							res_d.flag_i        = raw_q[0];
							res_d.flag_x        = addr_q[3];
							res_d.flag_b        = addr_q[2];
							res_d.flag_p        = addr_q[1];
							res_d.flag_e        = addr_q[0];
							res_d.operand_value = acc_disp;
							res_d.status        = sxd_pkg::ST_OK;
						end
					end
				end
				default: begin
					// halted: characters are drained and ignored
					mode_d = sxd_pkg::MODE_HALT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= sxd_pkg::MODE_SEEK;
			cc_q        <= 3'd0;
			bl_q        <= 8'd0;
			raw_q       <= 8'd0;
			addr_q      <= 4'd0;
			acc_q       <= 20'd0;
			out_valid_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			cc_q   <= cc_d;
			bl_q   <= bl_d;
			raw_q  <= raw_d;
			addr_q <= addr_d;
			acc_q  <= acc_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res_d;
		end
	end

	`SXD_ASSERT(a_halt_sticks, (mode_q == sxd_pkg::MODE_HALT) |=> (mode_q == sxd_pkg::MODE_HALT),
		"parser left the halted mode")
	`SXD_ASSERT(a_err_halts, (out_valid_q && out_q.status != sxd_pkg::ST_OK) |-> (mode_q == sxd_pkg::MODE_HALT),
		"error result while parser not halted")
	`SXD_ASSERT(a_addr_count, (mode_q == sxd_pkg::MODE_SKIPADDR) |-> (cc_q < 3'd6),
		"address skip counter out of range")

endmodule

// ===== sv/sic_xe_object_text_decoder_unit.sv =====
// Top level of the SIC/XE object text-record decoder.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | in        | in_valid / in_ready   | ch
//  out     | out       | out_valid / out_ready | opcode fmt flag_n..flag_e operand_value status
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index cfg_data
//
// One character transfer per cycle sustained while the output does not stall; the parser
// consumes one queued character per cycle and emits at most one result per character.
// A result becomes valid once the input character that completes it has passed the front
// register, a queue entry and the output register, in that order.
// Reset clears the parser, queue, output valid and both format tables to zero.
// A stalled output backs up the two-entry queue and the front register before in_ready drops.
// cfg_ready is always high; a table write takes effect at the next edge.
module sic_xe_object_text_decoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      ch,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      opcode,
	output logic [1:0]                      fmt,
	output logic                            flag_n,
	output logic                            flag_i,
	output logic                            flag_x,
	output logic                            flag_b,
	output logic                            flag_p,
	output logic                            flag_e,
	output logic [19:0]                     operand_value,
	output logic [1:0]                      status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sxd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sxd_pkg::TBL_W-1:0]       cfg_data
);

	// format tables, two bits per masked opcode
	logic [sxd_pkg::TBL_W-1:0] fmt_low_q, fmt_high_q;

	logic                fifo_full, fifo_not_empty, push, pop;
	sxd_pkg::char_info_t push_data, pop_data;
	sxd_pkg::result_t    res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_low_q  <= '0;
			fmt_high_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sxd_pkg::CFG_FMT_LOW:  fmt_low_q  <= cfg_data;
				sxd_pkg::CFG_FMT_HIGH: fmt_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: register and classify each character
	sxd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.fifo_full (fifo_full),
		.push      (push),
		.push_data (push_data)
	);

	// queue decouples front from parser stalls
	sxd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (fifo_full),
		.pop       (pop),
		.not_empty (fifo_not_empty),
		.pop_data  (pop_data)
	);

	// back: record parser and result register
	sxd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.fifo_not_empty (fifo_not_empty),
		.fifo_data      (pop_data),
		.pop            (pop),
		.fmt_low        (fmt_low_q),
		.fmt_high       (fmt_high_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result         (res)
	);

	assign opcode        = res.opcode;
	assign fmt           = res.fmt;
	assign flag_n        = res.flag_n;
	assign flag_i        = res.flag_i;
	assign flag_x        = res.flag_x;
	assign flag_b        = res.flag_b;
	assign flag_p        = res.flag_p;
	assign flag_e        = res.flag_e;
	assign operand_value = res.operand_value;
	assign status        = res.status;

endmodule
